// ----- hdl/sss_pkg.sv -----
// Shared types for the sequence substring search block.
// Holds the command codes and the control bundle sent to every match cell.
// No dependencies.
package sss_pkg;

	typedef enum logic [1:0] {
		CMD_APPEND = 2'd0,
		CMD_TEXT   = 2'd1,
		CMD_CLEAR  = 2'd2
	} cmd_t;

	typedef struct packed {
		logic       append;
		logic       text;
		logic       restart;
		logic       reverse;
		logic [7:0] symbol;
	} cell_ctrl_t;

endpackage

// ----- hdl/sss_cell.sv -----
// One position of the pattern: its stored symbol and its prefix match bit.
// Depends on sss_pkg for the control bundle.
module sss_cell #(
	parameter int INDEX = 0,
	parameter int LW    = 7
) (
	input  logic               clk,
	input  logic               arst_n,
	input  sss_pkg::cell_ctrl_t ctrl,
	input  logic [LW-1:0]      len,
	input  logic               left_in,
	input  logic               right_in,
	output logic               match,
	output logic               hit
);
	import sss_pkg::*;

	logic [7:0] sym_q;
	logic       match_q;
	logic       in_use;
	logic       is_last;
	logic       prev;
	logic       match_d;

	assign in_use  = len > LW'(INDEX);
	assign is_last = len == LW'(INDEX + 1);

	// Backwards matching runs the chain the other way, starting at the final cell.
	assign prev    = ctrl.reverse ? (is_last | right_in) : left_in;
	assign match_d = prev & in_use & (sym_q == ctrl.symbol);
	assign hit     = match_d & (ctrl.reverse ? (INDEX == 0) : is_last);
	assign match   = match_q;

	always_ff @(posedge clk) begin
		if (ctrl.append && len == LW'(INDEX)) begin
			sym_q <= ctrl.symbol;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (ctrl.restart) begin
			match_q <= 1'b0;
		end else if (ctrl.text) begin
			match_q <= match_d;
		end
	end

endmodule

// ----- hdl/sss_obuf.sv -----
// Two-entry result buffer between the match chain and the output channel.
// No dependencies.
module sss_obuf (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  logic push_data,
	input  logic pop,
	output logic full,
	output logic head_valid,
	output logic head_data
);

	logic [1:0] cnt_q;
	logic       slot0_q;
	logic       slot1_q;

	assign full       = cnt_q == 2'd2;
	assign head_valid = cnt_q != 2'd0;
	assign head_data  = slot0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (push && !pop) begin
			cnt_q <= cnt_q + 2'd1;
		end else if (pop && !push) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (push && cnt_q == 2'd1) begin
				slot0_q <= push_data;
			end else begin
				slot0_q <= slot1_q;
			end
			if (push && cnt_q == 2'd2) begin
				slot1_q <= push_data;
			end
		end else if (push) begin
			if (cnt_q == 2'd0) begin
				slot0_q <= push_data;
			end else begin
				slot1_q <= push_data;
			end
		end
	end

endmodule

// ----- hdl/sequence_substring_search.sv -----
// Top level of the sequence substring search block.
// Depends on sss_pkg, sss_cell and sss_obuf.
//
// Usage: items arrive on the input channel (in_valid, in_ready) with a command,
// a symbol and a last mark. An append item adds one symbol to the pattern, up to
// PATTERN_MAX symbols; further appends are dropped. A clear item empties the
// pattern. Text items stream through the search, one symbol per item. The item
// that carries a text symbol with last set produces one result on the output
// channel (out_valid, out_ready): found is high when the pattern occurred
// anywhere in the text since the previous restart. An empty pattern always
// reports found. Appends, clears and register writes restart the search.
// The register reverse_text (cfg_we, cfg_wdata) compares the pattern back to
// front and should be written only while the block is idle.
// Throughput is one item per clock while in_ready is high: every cell of the chain
// compares its pattern symbol with the incoming text symbol in the same cycle
// and passes its match bit to a neighbour. The result of a final text item is
// registered and shown after any earlier results. A two-entry result buffer
// decouples the sides, so input keeps flowing while a result waits; in_ready only
// drops when two results are held. Reset empties the pattern and the search
// state at once; there is no clearing pass.
module sequence_substring_search #(
	parameter int PATTERN_MAX = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] command,
	input  logic [7:0] symbol,
	input  logic       last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       found,
	input  logic       cfg_we,
	input  logic       cfg_wdata
);
	import sss_pkg::*;

	localparam int LW = $clog2(PATTERN_MAX + 1);

	logic                   accept;
	logic                   do_append;
	logic                   do_text;
	logic                   do_clear;
	logic                   report;
	logic                   found_d;
	logic                   buf_full;
	logic [LW-1:0]          len_q;
	logic                   found_q;
	logic                   reverse_q;
	cell_ctrl_t             ctrl;
	logic [PATTERN_MAX-1:0] match;
	logic [PATTERN_MAX-1:0] hit;

	assign in_ready = !buf_full;
	assign accept   = in_valid && in_ready;

	// Decode the accepted item. The unused command code does nothing.
	always_comb begin
		do_append = 1'b0;
		do_text   = 1'b0;
		do_clear  = 1'b0;
		unique case (cmd_t'(command))
			CMD_APPEND: do_append = accept;
			CMD_TEXT:   do_text   = accept;
			CMD_CLEAR:  do_clear  = accept;
			default: begin
			end
		endcase
	end

	assign report = do_text && last;

	// The search restarts after any pattern change, a register write and a report.
	assign ctrl.append  = do_append;
	assign ctrl.text    = do_text;
	assign ctrl.restart = do_append || do_clear || cfg_we || report;
	assign ctrl.reverse = reverse_q;
	assign ctrl.symbol  = symbol;

	// Only the cell that closes a whole pattern match can raise a hit, so the OR
	// is a plain reduction. An empty pattern matches on any text symbol.
	assign found_d = found_q || (|hit) || (len_q == '0);

	genvar gi;
	generate
		for (gi = 0; gi < PATTERN_MAX; gi++) begin : g_cell
			logic left_in;
			logic right_in;
			if (gi == 0) begin : g_first
				assign left_in = 1'b1;
			end else begin : g_mid_l
				assign left_in = match[gi-1];
			end
			if (gi == PATTERN_MAX - 1) begin : g_final
				assign right_in = 1'b0;
			end else begin : g_mid_r
				assign right_in = match[gi+1];
			end
			sss_cell #(
				.INDEX(gi),
				.LW   (LW)
			) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.ctrl    (ctrl),
				.len     (len_q),
				.left_in (left_in),
				.right_in(right_in),
				.match   (match[gi]),
				.hit     (hit[gi])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q     <= '0;
			found_q   <= 1'b0;
			reverse_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				reverse_q <= cfg_wdata;
			end
			if (do_clear) begin
				len_q <= '0;
			end else if (do_append && len_q < LW'(PATTERN_MAX)) begin
				len_q <= len_q + LW'(1);
			end
			if (ctrl.restart) begin
				found_q <= 1'b0;
			end else if (do_text) begin
				found_q <= found_d;
			end
		end
	end

	sss_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (report),
		.push_data (found_d),
		.pop       (out_valid && out_ready),
		.full      (buf_full),
		.head_valid(out_valid),
		.head_data (found)
	);

endmodule

// ----- hdl/sss_checker.sv -----
// Port-level checks for the sequence substring search block, bound to its top level.
// Depends on sss_pkg for the command codes.
module sss_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [1:0] command,
	input logic       last,
	input logic       out_valid,
	input logic       out_ready,
	input logic       found
);
	import sss_pkg::*;

	logic acc;
	assign acc = in_valid && in_ready;

	// A held result stays put until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(found))
		else $error("result changed while stalled");

	// Input is only held off while results are waiting.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with no pending result");

	// A final text item with nothing pending shows its result next cycle.
	a_report: assert property (@(posedge clk) disable iff (!arst_n)
		acc && command == CMD_TEXT && last && !out_valid |=> out_valid)
		else $error("missing result for final text item");

	// Items other than text never create a result.
	a_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		acc && command != CMD_TEXT && !out_valid |=> !out_valid)
		else $error("result from a non-text item");

	// After a clear the empty pattern matches any text.
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && command == CMD_CLEAR) ##1 (acc && command == CMD_TEXT && last && !out_valid)
		|=> out_valid && found)
		else $error("empty pattern did not report found");

endmodule

bind sequence_substring_search sss_checker u_sss_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.command  (command),
	.last     (last),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.found    (found)
);
